// ----- rtl/mtmb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the model matrix builder.
// Depends on nothing; every other file in rtl uses it by scoped names.
`default_nettype none

package mtmb_pkg;

    localparam int CordW         = 20;
    localparam int UnitW         = 18;
    localparam int RedW          = 19;
    localparam int RedSteps      = 14;
    localparam int RedHalf       = 7;
    localparam int CordSteps     = 16;
    localparam int StepsPerStage = 4;
    localparam int CordStages    = CordSteps / StepsPerStage;
    localparam int SinCosDepth   = 4 + CordStages;
    localparam int DivSteps      = 32;
    localparam int DivStages     = DivSteps / StepsPerStage;

    localparam logic [32:0] TwoPi = 33'd411775;
    localparam logic signed [CordW-1:0] TwoPiS      = 20'sd411775;
    localparam logic signed [CordW-1:0] PiQ         = 20'sd205887;
    localparam logic signed [CordW-1:0] PiHalf      = 20'sd102944;
    localparam logic signed [CordW-1:0] ThreeHalfPi = 20'sd308831;
    localparam logic signed [CordW-1:0] RedOffset   = 20'sd77023;
    localparam logic signed [CordW-1:0] CordicK     = 20'sd39797;
    localparam logic signed [CordW-1:0] OneC        = 20'sd65536;

    localparam logic signed [UnitW-1:0] OneU = 18'sd65536;
    localparam logic signed [31:0] OneQ  = 32'sd65536;
    localparam logic signed [31:0] Q16Max = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16Min = 32'sh8000_0000;
    localparam logic signed [33:0] Pow32  = 34'sh1_0000_0000;
    localparam logic signed [33:0] Max34  = 34'sh0_7FFF_FFFF;

    localparam logic [1:0] LastRow = 2'd3;
    localparam logic [1:0] ItemGap = 2'd3;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [UnitW-1:0] unit_t;

    typedef struct packed {
        logic kind;
        q16_t pos_x;
        q16_t pos_y;
        q16_t pos_z;
        q16_t angle_x;
        q16_t angle_y;
        q16_t angle_z;
        q16_t scale_x;
        q16_t scale_y;
        q16_t scale_z;
    } xform_t;

    typedef struct packed {
        logic [1:0] row_index;
        q16_t       col0;
        q16_t       col1;
        q16_t       col2;
        q16_t       col3;
        logic       div_by_zero;
        logic       last;
    } row_t;

    typedef struct packed {
        unit_t s;
        unit_t c;
    } sincos_t;

    typedef struct packed {
        logic       kind;
        q16_t [2:0] pos;
        q16_t [2:0] scale;
    } side_t;

    typedef struct packed {
        q16_t [2:0] rcp;
        logic       dz;
    } recip_t;

    typedef struct packed {
        q16_t [3:0][3:0] m;
        logic            dz;
    } mat_t;

    function automatic logic signed [CordW-1:0] atan_at(input int i);
        logic signed [CordW-1:0] v;
        case (i)
            0:  v = 20'sd51472;
            1:  v = 20'sd30386;
            2:  v = 20'sd16055;
            3:  v = 20'sd8150;
            4:  v = 20'sd4091;
            5:  v = 20'sd2047;
            6:  v = 20'sd1024;
            7:  v = 20'sd512;
            8:  v = 20'sd256;
            9:  v = 20'sd128;
            10: v = 20'sd64;
            11: v = 20'sd32;
            12: v = 20'sd16;
            13: v = 20'sd8;
            14: v = 20'sd4;
            15: v = 20'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t[63:16];
    endfunction

    function automatic q16_t sat32(input logic signed [63:0] v);
        q16_t r;
        if (v > 64'(Q16Max))
        begin
            r = Q16Max;
        end
        else if (v < 64'(Q16Min))
        begin
            r = Q16Min;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic unit_t mul_unit(input unit_t a, input unit_t b);
        logic signed [2*UnitW-1:0] p;
        logic signed [47:0]        t;
        p = a * b;
        t = rnd16(64'(p));
        return t[UnitW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mtmb_sincos.sv -----
// Three-lane sine/cosine pipeline: angle reduction mod 2*pi, quadrant fold,
// 16 CORDIC steps over four stages, clamp. Depends on mtmb_pkg.
`default_nettype none

module mtmb_sincos (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire mtmb_pkg::q16_t [2:0]      angle,
    output logic                           out_valid,
    output mtmb_pkg::sincos_t [2:0]        sc
);

    localparam int Depth = mtmb_pkg::SinCosDepth;
    localparam int CW    = mtmb_pkg::CordW;
    localparam int CS    = mtmb_pkg::CordStages;
    localparam int SPS   = mtmb_pkg::StepsPerStage;

    logic [Depth-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[Depth-1];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        logic [31:0]                   red1_reg, red1_next;
        logic [mtmb_pkg::RedW-1:0]     red2_reg, red2_next;
        logic signed [CW-1:0]          z0_reg, z0_next;
        logic                          neg0_reg, neg0_next;
        logic signed [CW-1:0]          x_in [CS];
        logic signed [CW-1:0]          y_in [CS];
        logic signed [CW-1:0]          z_in [CS];
        logic signed [CW-1:0]          x_reg [CS];
        logic signed [CW-1:0]          y_reg [CS];
        logic signed [CW-1:0]          z_reg [CS];
        logic signed [CW-1:0]          x_next [CS];
        logic signed [CW-1:0]          y_next [CS];
        logic signed [CW-1:0]          z_next [CS];
        logic [CS-1:0]                 neg_reg;
        mtmb_pkg::sincos_t             sc_reg, sc_next;

        always_comb
        begin
            logic [32:0] u;
            u = {1'b0, ~angle[g][31], angle[g][30:0]};
            for (int k = mtmb_pkg::RedSteps - 1; k >= mtmb_pkg::RedHalf; k--)
            begin
                if (u >= (mtmb_pkg::TwoPi << k))
                begin
                    u = u - (mtmb_pkg::TwoPi << k);
                end
            end
            red1_next = u[31:0];
        end

        always_comb
        begin
            logic [32:0] u;
            u = {1'b0, red1_reg};
            for (int k = mtmb_pkg::RedHalf - 1; k >= 0; k--)
            begin
                if (u >= (mtmb_pkg::TwoPi << k))
                begin
                    u = u - (mtmb_pkg::TwoPi << k);
                end
            end
            red2_next = u[mtmb_pkg::RedW-1:0];
        end

        always_comb
        begin
            logic signed [CW-1:0] rr;
            rr = $signed({1'b0, red2_reg}) - mtmb_pkg::RedOffset;
            if (rr < 0)
            begin
                rr = rr + mtmb_pkg::TwoPiS;
            end
            neg0_next = 1'b0;
            if (rr <= mtmb_pkg::PiHalf)
            begin
                z0_next = rr;
            end
            else if (rr < mtmb_pkg::ThreeHalfPi)
            begin
                z0_next   = mtmb_pkg::PiQ - rr;
                neg0_next = 1'b1;
            end
            else
            begin
                z0_next = rr - mtmb_pkg::TwoPiS;
            end
        end

        for (genvar s = 0; s < CS; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign x_in[s] = mtmb_pkg::CordicK;
                assign y_in[s] = '0;
                assign z_in[s] = z0_reg;
            end
            else
            begin : g_rest
                assign x_in[s] = x_reg[s-1];
                assign y_in[s] = y_reg[s-1];
                assign z_in[s] = z_reg[s-1];
            end

            always_comb
            begin
                logic signed [CW-1:0] x, y, z, dx, dy;
                x = x_in[s];
                y = y_in[s];
                z = z_in[s];
                for (int j = 0; j < SPS; j++)
                begin
                    dx = y >>> (s * SPS + j);
                    dy = x >>> (s * SPS + j);
                    if (z >= 0)
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - mtmb_pkg::atan_at(s * SPS + j);
                    end
                    else
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + mtmb_pkg::atan_at(s * SPS + j);
                    end
                end
                x_next[s] = x;
                y_next[s] = y;
                z_next[s] = z;
            end
        end

        always_comb
        begin
            logic signed [CW-1:0] cv, sv;
            sv = y_reg[CS-1];
            cv = neg_reg[CS-1] ? -x_reg[CS-1] : x_reg[CS-1];
            if (sv > mtmb_pkg::OneC)
            begin
                sc_next.s = mtmb_pkg::OneU;
            end
            else if (sv < -mtmb_pkg::OneC)
            begin
                sc_next.s = -mtmb_pkg::OneU;
            end
            else
            begin
                sc_next.s = sv[mtmb_pkg::UnitW-1:0];
            end
            if (cv > mtmb_pkg::OneC)
            begin
                sc_next.c = mtmb_pkg::OneU;
            end
            else if (cv < -mtmb_pkg::OneC)
            begin
                sc_next.c = -mtmb_pkg::OneU;
            end
            else
            begin
                sc_next.c = cv[mtmb_pkg::UnitW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            red1_reg   <= red1_next;
            red2_reg   <= red2_next;
            z0_reg     <= z0_next;
            neg0_reg   <= neg0_next;
            neg_reg[0] <= neg0_reg;
            for (int k = 1; k < CS; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 0; k < CS; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            sc_reg <= sc_next;
        end

        assign sc[g] = sc_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/mtmb_recip.sv -----
// Three-lane pipelined reciprocal 2^32 / scale, four restoring steps per stage,
// saturated to Q16.16, with zero-scale flag. Depends on mtmb_pkg.
`default_nettype none

module mtmb_recip (
    input  wire logic                 clk,
    input  wire mtmb_pkg::q16_t [2:0] scale,
    output mtmb_pkg::recip_t          rcp
);

    localparam int DS  = mtmb_pkg::DivStages;
    localparam int SPS = mtmb_pkg::StepsPerStage;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;
        logic        zero;
        logic        one;
    } div_t;

    logic [2:0] lane_z;

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        div_t                div_reg  [DS+1];
        div_t                div_next [DS+1];
        logic signed [33:0]  val_reg, val_next;
        logic                zero_reg;
        mtmb_pkg::q16_t      sat_reg;
        logic                zsat_reg;

        always_comb
        begin
            div_next[0].neg  = scale[g][31];
            div_next[0].dvs  = scale[g][31] ? 32'(-scale[g]) : 32'(scale[g]);
            div_next[0].zero = (scale[g] == 32'sd0);
            div_next[0].one  = (scale[g] == 32'sd1) || (scale[g] == -32'sd1);
            div_next[0].rem  = 32'd1;
            div_next[0].quo  = '0;
        end

        for (genvar s = 0; s < DS; s++)
        begin : g_stage
            always_comb
            begin
                div_t        cur;
                logic [32:0] t;
                logic        qb;
                cur = div_reg[s];
                for (int j = 0; j < SPS; j++)
                begin
                    t  = {cur.rem, 1'b0};
                    qb = 1'b0;
                    if (t >= {1'b0, cur.dvs})
                    begin
                        t  = t - {1'b0, cur.dvs};
                        qb = 1'b1;
                    end
                    cur.rem = t[31:0];
                    cur.quo = {cur.quo[30:0], qb};
                end
                div_next[s+1] = cur;
            end
        end

        always_comb
        begin
            if (div_reg[DS].zero)
            begin
                val_next = mtmb_pkg::Max34;
            end
            else if (div_reg[DS].one)
            begin
                val_next = div_reg[DS].neg ? -mtmb_pkg::Pow32 : mtmb_pkg::Pow32;
            end
            else if (div_reg[DS].neg)
            begin
                val_next = -$signed({2'b00, div_reg[DS].quo});
            end
            else
            begin
                val_next = $signed({2'b00, div_reg[DS].quo});
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k <= DS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            val_reg  <= val_next;
            zero_reg <= div_reg[DS].zero;
            sat_reg  <= mtmb_pkg::sat32(64'(val_reg));
            zsat_reg <= zero_reg;
        end

        assign rcp.rcp[g] = sat_reg;
        assign lane_z[g]  = zsat_reg;
    end

    assign rcp.dz = |lane_z;

endmodule

`default_nettype wire

// ----- rtl/mtmb_matrix.sv -----
// Matrix datapath: rotation Rx*Ry*Rz, scale or reciprocal-scale products and
// the translation or inverse translation row, seven register stages. Depends on mtmb_pkg.
`default_nettype none

module mtmb_matrix (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire mtmb_pkg::sincos_t [2:0]     sc,
    input  wire mtmb_pkg::side_t             side,
    input  wire mtmb_pkg::recip_t            rcp,
    output logic                             out_valid,
    output mtmb_pkg::mat_t                   mat
);

    localparam int Depth = 7;
    localparam int SideD = 6;

    typedef logic signed [mtmb_pkg::UnitW:0] rot_t;
    typedef logic signed [50:0]              prod_t;
    typedef logic signed [63:0]              wide_t;

    logic [Depth-1:0] vld_reg;

    mtmb_pkg::side_t  side_reg [SideD];
    mtmb_pkg::unit_t  p_reg [3][3];
    mtmb_pkg::unit_t  p_next [3][3];
    mtmb_pkg::unit_t  cx_reg, sx_reg;
    mtmb_pkg::unit_t  a_reg [4][3];
    mtmb_pkg::unit_t  a_next [4][3];
    mtmb_pkg::unit_t  r0_reg [3];
    rot_t             r_reg [3][3];
    rot_t             r_next [3][3];
    prod_t            prod_reg [3][3];
    prod_t            prod_next [3][3];
    mtmb_pkg::q16_t   np_reg [3];
    mtmb_pkg::q16_t   np_next [3];
    mtmb_pkg::q16_t   np5_reg [3];
    mtmb_pkg::q16_t   e_reg [3][3];
    mtmb_pkg::q16_t   e6_reg [3][3];
    wide_t            q_reg [3][3];
    wide_t            q_next [3][3];
    logic [2:0]       dz_reg;
    mtmb_pkg::mat_t   mat_reg, mat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[Depth-1];

    always_comb
    begin
        p_next[0][0] = mtmb_pkg::mul_unit(sc[1].c, sc[2].c);
        p_next[0][1] = mtmb_pkg::mul_unit(sc[1].c, -sc[2].s);
        p_next[0][2] = sc[1].s;
        p_next[1][0] = sc[2].s;
        p_next[1][1] = sc[2].c;
        p_next[1][2] = '0;
        p_next[2][0] = mtmb_pkg::mul_unit(-sc[1].s, sc[2].c);
        p_next[2][1] = mtmb_pkg::mul_unit(-sc[1].s, -sc[2].s);
        p_next[2][2] = sc[1].c;
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_next[0][j] = mtmb_pkg::mul_unit(cx_reg, p_reg[1][j]);
            a_next[1][j] = mtmb_pkg::mul_unit(-sx_reg, p_reg[2][j]);
            a_next[2][j] = mtmb_pkg::mul_unit(sx_reg, p_reg[1][j]);
            a_next[3][j] = mtmb_pkg::mul_unit(cx_reg, p_reg[2][j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            r_next[0][j] = rot_t'(r0_reg[j]);
            r_next[1][j] = rot_t'(a_reg[0][j]) + rot_t'(a_reg[1][j]);
            r_next[2][j] = rot_t'(a_reg[2][j]) + rot_t'(a_reg[3][j]);
        end
    end

    always_comb
    begin
        mtmb_pkg::q16_t op_s;
        rot_t           op_r;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (side_reg[2].kind)
                begin
                    op_s = rcp.rcp[j];
                    op_r = r_reg[j][i];
                end
                else
                begin
                    op_s = side_reg[2].scale[i];
                    op_r = r_reg[i][j];
                end
                prod_next[i][j] = op_s * op_r;
            end
            np_next[i] = mtmb_pkg::sat32(-64'(side_reg[2].pos[i]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q_next[k][j] = 64'(np5_reg[k]) * 64'(e_reg[k][j]);
            end
        end
    end

    always_comb
    begin
        wide_t sum;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat_next.m[i][j] = e6_reg[i][j];
            end
            mat_next.m[i][3] = '0;
        end
        for (int j = 0; j < 3; j++)
        begin
            sum = 64'(mtmb_pkg::rnd16(q_reg[0][j])) + 64'(mtmb_pkg::rnd16(q_reg[1][j]))
                + 64'(mtmb_pkg::rnd16(q_reg[2][j]));
            mat_next.m[3][j] = side_reg[SideD-1].kind ? mtmb_pkg::sat32(sum)
                                                      : side_reg[SideD-1].pos[j];
        end
        mat_next.m[3][3] = mtmb_pkg::OneQ;
        mat_next.dz      = dz_reg[2];
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side;
        for (int k = 1; k < SideD; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        p_reg  <= p_next;
        cx_reg <= sc[0].c;
        sx_reg <= sc[0].s;
        a_reg  <= a_next;
        for (int j = 0; j < 3; j++)
        begin
            r0_reg[j] <= p_reg[0][j];
        end
        r_reg     <= r_next;
        prod_reg  <= prod_next;
        np_reg    <= np_next;
        dz_reg[0] <= side_reg[2].kind & rcp.dz;
        dz_reg[1] <= dz_reg[0];
        dz_reg[2] <= dz_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e_reg[i][j] <= mtmb_pkg::sat32(64'(mtmb_pkg::rnd16(64'(prod_reg[i][j]))));
            end
        end
        np5_reg <= np_reg;
        e6_reg  <= e_reg;
        q_reg   <= q_next;
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

// ----- rtl/model_transform_matrix_builder.sv -----
// Top level of the model matrix builder: input register, sine/cosine and
// reciprocal pipelines, matrix datapath, four-beat row serializer. Uses mtmb_pkg.
`default_nettype none

// A transform is taken when start is high and busy is low; busy then stays
// high while its gap counter runs down, so transforms are spaced to match the
// four row beats of the result port. Row 0 appears on result with result_valid
// once the matrix leaves the datapath, and rows 1 to 3 follow back to back,
// each for exactly one cycle; last marks row 3. The receiver cannot hold rows
// off. The datapath is a 16-stage pipeline (angle reduction, CORDIC, pipelined
// reciprocal, matrix products) with no stalls.

module model_transform_matrix_builder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mtmb_pkg::xform_t xform,
    output logic                  busy,
    output logic                  result_valid,
    output mtmb_pkg::row_t        result
);

    localparam int SideD = mtmb_pkg::SinCosDepth;

    logic                       in_vld_reg;
    mtmb_pkg::xform_t           in_reg;
    logic [1:0]                 gap_reg;
    mtmb_pkg::side_t            side_reg [SideD];
    mtmb_pkg::side_t            side_next;
    mtmb_pkg::q16_t [2:0]       angle;
    mtmb_pkg::q16_t [2:0]       scale;
    mtmb_pkg::sincos_t [2:0]    sc;
    logic                       sc_valid;
    mtmb_pkg::recip_t           rcp;
    logic                       mat_valid;
    mtmb_pkg::mat_t             mat;
    mtmb_pkg::mat_t             hold_reg;
    logic                       act_reg;
    logic [1:0]                 phase_reg;
    logic                       accept;

    assign accept = start && !busy;
    assign busy   = (gap_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            gap_reg    <= '0;
            act_reg    <= 1'b0;
            phase_reg  <= '0;
        end
        else
        begin
            in_vld_reg <= accept;
            if (accept)
            begin
                gap_reg <= mtmb_pkg::ItemGap;
            end
            else if (busy)
            begin
                gap_reg <= gap_reg - 2'd1;
            end
            if (mat_valid)
            begin
                act_reg   <= 1'b1;
                phase_reg <= '0;
            end
            else if (act_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == mtmb_pkg::LastRow)
                begin
                    act_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        angle[0] = in_reg.angle_x;
        angle[1] = in_reg.angle_y;
        angle[2] = in_reg.angle_z;
        scale[0] = in_reg.scale_x;
        scale[1] = in_reg.scale_y;
        scale[2] = in_reg.scale_z;
        side_next.kind     = in_reg.kind;
        side_next.pos[0]   = in_reg.pos_x;
        side_next.pos[1]   = in_reg.pos_y;
        side_next.pos[2]   = in_reg.pos_z;
        side_next.scale    = scale;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= xform;
        end
        side_reg[0] <= side_next;
        for (int k = 1; k < SideD; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        if (mat_valid)
        begin
            hold_reg <= mat;
        end
    end

    mtmb_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .angle     (angle),
        .out_valid (sc_valid),
        .sc        (sc)
    );

    mtmb_recip u_recip (
        .clk   (clk),
        .scale (scale),
        .rcp   (rcp)
    );

    mtmb_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .sc        (sc),
        .side      (side_reg[SideD-1]),
        .rcp       (rcp),
        .out_valid (mat_valid),
        .mat       (mat)
    );

    always_comb
    begin
        result.row_index   = phase_reg;
        result.col0        = hold_reg.m[phase_reg][0];
        result.col1        = hold_reg.m[phase_reg][1];
        result.col2        = hold_reg.m[phase_reg][2];
        result.col3        = hold_reg.m[phase_reg][3];
        result.div_by_zero = hold_reg.dz;
        result.last        = (phase_reg == mtmb_pkg::LastRow);
    end

    assign result_valid = act_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted beat");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid |-> (!act_reg || phase_reg == mtmb_pkg::LastRow))
        else $error("new matrix arrived while rows still pending");

    a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.row_index != mtmb_pkg::LastRow) |=>
        (result_valid && result.row_index == $past(result.row_index) + 2'd1))
        else $error("row beats not consecutive");
`endif

endmodule

`default_nettype wire

// ----- test/model_transform_matrix_builder_tb.sv -----
// Testbench for model_transform_matrix_builder: drives transforms through the
// start/busy port and checks each row beat against a built-in fixed-point predictor.
// Depends on mtmb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module model_transform_matrix_builder_tb;

    localparam longint TwoPiL = 411775;
    localparam longint PiL = 205887;
    localparam longint PiHalfL = 102944;
    localparam longint ThreeHalfL = 308831;
    localparam longint OneL = 65536;
    localparam longint I32Max = 64'sd2147483647;
    localparam longint I32Min = -64'sd2147483648;
    localparam int Latency = 20;

    typedef longint mat4_t [4][4];

    logic clk;
    logic rst_n;
    logic start;
    mtmb_pkg::xform_t xform;
    logic busy;
    logic result_valid;
    mtmb_pkg::row_t result;

    mtmb_pkg::row_t expected_rows[$];
    int mismatches;

    model_transform_matrix_builder i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .xform(xform),
        .busy(busy),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clip32(longint v);
        if (v > I32Max)
        begin
            return I32Max;
        end
        if (v < I32Min)
        begin
            return I32Min;
        end
        return v;
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > OneL)
        begin
            return OneL;
        end
        if (v < -OneL)
        begin
            return -OneL;
        end
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint r;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit neg_cos;
        r = ang % TwoPiL;
        if (r < 0)
        begin
            r += TwoPiL;
        end
        neg_cos = 0;
        if (r <= PiHalfL)
        begin
            z = r;
        end
        else if (r < ThreeHalfL)
        begin
            z = PiL - r;
            neg_cos = 1;
        end
        else
        begin
            z = r - TwoPiL;
        end
        x = 39797;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        s = clip_unit(y);
        c = clip_unit(neg_cos ? -x : x);
    endtask

    function automatic mat4_t unit_mat();
        mat4_t m;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                m[i][j] = (i == j) ? OneL : 0;
            end
        end
        return m;
    endfunction

    function automatic mat4_t mat_product(mat4_t a, mat4_t b);
        mat4_t r;
        longint acc;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                begin
                    acc += (a[i][k] * b[k][j] + 32768) >>> 16;
                end
                r[i][j] = clip32(acc);
            end
        end
        return r;
    endfunction

    task automatic predict_rows(input mtmb_pkg::xform_t x);
        mat4_t rx;
        mat4_t ry;
        mat4_t rz;
        mat4_t rot;
        mat4_t sm;
        mat4_t tm;
        mat4_t rt;
        mat4_t res;
        longint s;
        longint c;
        longint pos[3];
        longint scl[3];
        bit dz;
        mtmb_pkg::row_t row;
        pos = '{longint'(x.pos_x), longint'(x.pos_y), longint'(x.pos_z)};
        scl = '{longint'(x.scale_x), longint'(x.scale_y), longint'(x.scale_z)};
        rx = unit_mat();
        ry = unit_mat();
        rz = unit_mat();
        sin_cos(longint'(x.angle_x), s, c);
        rx[1][1] = c; rx[1][2] = -s; rx[2][1] = s; rx[2][2] = c;
        sin_cos(longint'(x.angle_y), s, c);
        ry[0][0] = c; ry[0][2] = s; ry[2][0] = -s; ry[2][2] = c;
        sin_cos(longint'(x.angle_z), s, c);
        rz[0][0] = c; rz[0][1] = -s; rz[1][0] = s; rz[1][1] = c;
        rot = mat_product(rx, mat_product(ry, rz));
        sm = unit_mat();
        tm = unit_mat();
        dz = 0;
        if (!x.kind)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sm[i][i] = scl[i];
                tm[3][i] = pos[i];
            end
            res = mat_product(sm, mat_product(rot, tm));
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (scl[i] == 0)
                begin
                    sm[i][i] = I32Max;
                    dz = 1;
                end
                else
                begin
                    sm[i][i] = clip32(64'sd4294967296 / scl[i]);
                end
                tm[3][i] = clip32(-pos[i]);
            end
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    rt[i][j] = rot[j][i];
                end
            end
            res = mat_product(tm, mat_product(rt, sm));
        end
        for (int i = 0; i < 4; i++)
        begin
            row.row_index = 2'(i);
            row.col0 = mtmb_pkg::q16_t'(res[i][0]);
            row.col1 = mtmb_pkg::q16_t'(res[i][1]);
            row.col2 = mtmb_pkg::q16_t'(res[i][2]);
            row.col3 = mtmb_pkg::q16_t'(res[i][3]);
            row.div_by_zero = dz;
            row.last = (i == 3);
            expected_rows.push_back(row);
        end
    endtask

    always @(posedge clk)
    begin
        mtmb_pkg::row_t exp_row;
        if (rst_n && result_valid)
        begin
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected row beat %p", result);
                end
            end
            else
            begin
                exp_row = expected_rows.pop_front();
                if (result !== exp_row)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("row mismatch: expected %p actual %p", exp_row, result);
                    end
                end
            end
        end
    end

    int burst_left;

    task automatic send_xform(input mtmb_pkg::xform_t x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 9) : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        xform <= x;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_rows(x);
    endtask

    function automatic mtmb_pkg::q16_t rand_q16(int mode);
        case (mode)
            0: return mtmb_pkg::q16_t'($urandom);
            1: return mtmb_pkg::q16_t'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            2: return mtmb_pkg::q16_t'(int'($urandom_range(0, 2000)) - 1000);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return mtmb_pkg::Q16Max;
                    1: return mtmb_pkg::Q16Min;
                    2: return '0;
                    3: return mtmb_pkg::OneQ;
                    4: return -mtmb_pkg::OneQ;
                    default: return mtmb_pkg::q16_t'(int'($urandom_range(0, 4)) - 2);
                endcase
            end
        endcase
    endfunction

    function automatic mtmb_pkg::xform_t rand_xform();
        mtmb_pkg::xform_t x;
        x.kind = 1'($urandom_range(0, 1));
        x.pos_x = rand_q16($urandom_range(0, 3));
        x.pos_y = rand_q16($urandom_range(0, 3));
        x.pos_z = rand_q16($urandom_range(0, 3));
        x.angle_x = rand_q16($urandom_range(0, 3));
        x.angle_y = rand_q16($urandom_range(0, 3));
        x.angle_z = rand_q16($urandom_range(0, 3));
        x.scale_x = rand_q16($urandom_range(0, 3));
        x.scale_y = rand_q16($urandom_range(0, 3));
        x.scale_z = rand_q16($urandom_range(0, 3));
        return x;
    endfunction

    function automatic mtmb_pkg::xform_t plain_xform(logic k, mtmb_pkg::q16_t p,
                                                     mtmb_pkg::q16_t a, mtmb_pkg::q16_t s);
        mtmb_pkg::xform_t x;
        x.kind = k;
        x.pos_x = p; x.pos_y = p; x.pos_z = p;
        x.angle_x = a; x.angle_y = a; x.angle_z = a;
        x.scale_x = s; x.scale_y = s; x.scale_z = s;
        return x;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_rows.size() != 0);
    endtask

    task automatic test_field_extremes();
        for (int k = 0; k < 2; k++)
        begin
            send_xform(plain_xform(k[0], '0, '0, mtmb_pkg::OneQ));
            send_xform(plain_xform(k[0], mtmb_pkg::Q16Max, mtmb_pkg::Q16Max,
                                   mtmb_pkg::Q16Max));
            send_xform(plain_xform(k[0], mtmb_pkg::Q16Min, mtmb_pkg::Q16Min,
                                   mtmb_pkg::Q16Min));
            send_xform(plain_xform(k[0], -mtmb_pkg::OneQ, 32'sd102944, -mtmb_pkg::OneQ));
            send_xform(plain_xform(k[0], 32'sd3 <<< 16, 32'sd205887, 32'sd2 <<< 16));
            send_xform(plain_xform(k[0], -32'sd5, 32'sd308831, 32'sd411775));
            send_xform(plain_xform(k[0], 32'sd12345, -32'sd411775, 32'sd1));
        end
    endtask

    task automatic test_inverse_special();
        mtmb_pkg::xform_t x;
        x = plain_xform(1'b1, 32'sd65536, 32'sd30000, mtmb_pkg::OneQ);
        x.scale_y = '0;
        send_xform(x);
        send_xform(plain_xform(1'b1, mtmb_pkg::Q16Min, '0, '0));
        x = plain_xform(1'b1, '0, -32'sd70000, -32'sd1);
        x.scale_z = 32'sd2;
        send_xform(x);
        send_xform(plain_xform(1'b0, mtmb_pkg::Q16Max, 32'sd1000, '0));
        wait_drained();
    endtask

    task automatic test_random_transforms();
        for (int n = 0; n < 280; n++)
        begin
            if (n == 140)
            begin
                wait_drained();
            end
            send_xform(rand_xform());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        xform = '0;
        mismatches = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_inverse_special();
        test_random_transforms();
        wait_drained();
        repeat (Latency) @(posedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mtmb_pkg.sv
rtl/mtmb_sincos.sv
rtl/mtmb_recip.sv
rtl/mtmb_matrix.sv
rtl/model_transform_matrix_builder.sv
test/model_transform_matrix_builder_tb.sv
